>>> rtl/core/mstseq_pkg.sv
`default_nettype none
package mstseq_pkg;

	localparam int unsigned HIGHEST_NOTE_DEF = 108;

	// Dividend of the whole-note length in ms, and the quotient width it needs
	localparam logic [17:0] WHOLE_MS = 18'd240000;
	localparam int unsigned DIV_STEPS = 18;

	typedef struct packed {
		logic [7:0] char_code;
		logic       line_end;
	} in_word_t;

	typedef struct packed {
		logic [6:0]  note_number;
		logic [15:0] duration_ms;
		logic        last_of_run;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIVIDE,
		ST_SCALE,
		ST_EMIT_A,
		ST_EMIT_B
	} state_t;

	typedef enum logic [1:0] {
		ART_NORMAL   = 2'd0,
		ART_LEGATO   = 2'd1,
		ART_STACCATO = 2'd2
	} art_t;

	typedef struct packed {
		logic load;
		logic div_step;
		logic scale;
		logic sel_second;
	} dp_cmd_t;

	typedef struct packed {
		logic play_req;
		logic two;
		logic div_last;
	} dp_status_t;

endpackage
`default_nettype wire

>>> rtl/core/mstseq_ctrl.sv
`default_nettype none
module mstseq_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   in_valid,
	input  wire logic                   out_ready,
	input  wire mstseq_pkg::dp_status_t status,
	output logic                        in_ready,
	output logic                        out_valid,
	output mstseq_pkg::dp_cmd_t         cmd
);

	mstseq_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mstseq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			mstseq_pkg::ST_IDLE: begin
				if (in_valid && status.play_req) state_d = mstseq_pkg::ST_DIVIDE;
			end
			mstseq_pkg::ST_DIVIDE: begin
				if (status.div_last) state_d = mstseq_pkg::ST_SCALE;
			end
			mstseq_pkg::ST_SCALE: state_d = mstseq_pkg::ST_EMIT_A;
			mstseq_pkg::ST_EMIT_A: begin
				if (out_ready) state_d = status.two ? mstseq_pkg::ST_EMIT_B : mstseq_pkg::ST_IDLE;
			end
			mstseq_pkg::ST_EMIT_B: begin
				if (out_ready) state_d = mstseq_pkg::ST_IDLE;
			end
			default: state_d = mstseq_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready       = 1'b0;
		out_valid      = 1'b0;
		cmd            = '0;
		case (state_q)
			mstseq_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			mstseq_pkg::ST_DIVIDE: cmd.div_step = 1'b1;
			mstseq_pkg::ST_SCALE:  cmd.scale = 1'b1;
			mstseq_pkg::ST_EMIT_A: out_valid = 1'b1;
			mstseq_pkg::ST_EMIT_B: begin
				out_valid      = 1'b1;
				cmd.sel_second = 1'b1;
			end
			default: in_ready = 1'b0;
		endcase
	end

endmodule
`default_nettype wire

>>> rtl/core/mstseq_dp.sv
`default_nettype none
module mstseq_dp #(
	parameter int unsigned HIGHEST_NOTE = mstseq_pkg::HIGHEST_NOTE_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire mstseq_pkg::in_word_t  in_word,
	input  wire mstseq_pkg::dp_cmd_t   cmd,
	output mstseq_pkg::dp_status_t     status,
	output mstseq_pkg::out_word_t      out_word
);

	localparam logic [7:0] CH_NUL = 8'h00, CH_TAB = 8'h09, CH_CR = 8'h0D, CH_SP = 8'h20;
	localparam logic [7:0] CH_DOT = 8'h2E, CH_HASH = 8'h23, CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D, CH_UNDER = 8'h5F, CH_TILDE = 8'h7E;
	localparam logic [7:0] CH_LT = 8'h3C, CH_GT = 8'h3E, CH_0 = 8'h30, CH_9 = 8'h39;
	localparam logic [7:0] CH_A = 8'h41, CH_G = 8'h47, CH_L = 8'h4C, CH_M = 8'h4D;
	localparam logic [7:0] CH_N = 8'h4E, CH_O = 8'h4F, CH_P = 8'h50, CH_S = 8'h53;
	localparam logic [7:0] CH_T = 8'h54, CH_LA = 8'h61, CH_LZ = 8'h7A;
	localparam logic signed [14:0] NOTE_HI = 15'(HIGHEST_NOTE);

	// line state
	logic [7:0]        pend_q, pend_d, sub_q, sub_d;
	logic [13:0]       num_q, num_d;
	logic              in_run_q, in_run_d, legato_q, legato_d, skip_q, skip_d;
	logic signed [1:0] acc_q, acc_d;
	logic [3:0]        dots_q, dots_d;
	// player state
	logic signed [4:0] oct_q, oct_d, prev_q, prev_d;
	logic              track_q, track_d;
	logic [13:0]       deflen_q, deflen_d;
	logic [8:0]        tempo_q, tempo_d;
	mstseq_pkg::art_t  art_q, art_d;

	// latched event
	logic [6:0]  note_q;
	logic        two_q, stac_q;
	logic [3:0]  evdots_q;
	logic [22:0] den_q, rem_q;
	logic [17:0] quo_q;
	logic [4:0]  cnt_q;
	logic [15:0] dur_a_q, dur_b_q;

	logic [7:0]        c, u;
	logic              run, clr, new_pend, is_play, is_pause;
	logic [17:0]       mul10;
	logic [3:0]        idx;
	logic signed [5:0] diff;
	logic signed [4:0] oct_adj;
	logic signed [14:0] oct_ext, note_val;
	mstseq_pkg::art_t  art_eff;
	logic [13:0]       len_sel, p_len;
	logic              p_rest, p_in, p_two;
	logic [22:0]       den_new;

	function automatic logic [3:0] letter_index(input logic [2:0] k);
		logic [3:0] r;
		case (k)
			3'd0: r = 4'd9;
			3'd1: r = 4'd11;
			3'd2: r = 4'd0;
			3'd3: r = 4'd2;
			3'd4: r = 4'd4;
			3'd5: r = 4'd5;
			3'd6: r = 4'd7;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	always_comb begin
		c        = in_word.char_code;
		u        = (c >= CH_LA && c <= CH_LZ) ? (c - 8'd32) : c;
		pend_d   = pend_q;
		sub_d    = sub_q;
		num_d    = num_q;
		in_run_d = in_run_q;
		acc_d    = acc_q;
		dots_d   = dots_q;
		legato_d = legato_q;
		skip_d   = skip_q;
		run      = 1'b0;
		clr      = 1'b0;
		new_pend = 1'b0;
		mul10    = {1'b0, num_q, 3'b0} + {3'b0, num_q, 1'b0} + {14'd0, c[3:0]};

		if (in_word.line_end) begin
			run    = !skip_q;
			clr    = 1'b1;
			skip_d = 1'b0;
		end else if (skip_q) begin
			skip_d = 1'b1;
		end else if (c >= CH_0 && c <= CH_9) begin
			if (!in_run_q) num_d = {10'd0, c[3:0]};
			else if (num_q > 14'd999 || mul10 > 18'd9999) num_d = 14'd9999;
			else num_d = mul10[13:0];
			in_run_d = 1'b1;
		end else begin
			in_run_d = 1'b0;
			if (c == CH_SP || (c >= CH_TAB && c <= CH_CR)) begin
				in_run_d = 1'b0;
			end else if (c == CH_DOT) begin
				if (dots_q != 4'd15) dots_d = dots_q + 4'd1;
			end else if (c == CH_HASH || c == CH_PLUS) begin
				acc_d = 2'sd1;
			end else if (c == CH_MINUS) begin
				acc_d = -2'sd1;
			end else if (c == CH_UNDER) begin
				legato_d = 1'b1;
			end else if (pend_q == CH_M && sub_q == CH_NUL &&
			             (u == CH_N || u == CH_L || u == CH_S)) begin
				sub_d = u;
			end else if (pend_q == CH_O && sub_q == CH_NUL && (u == CH_L || u == CH_N)) begin
				sub_d = u;
			end else if (c == CH_NUL) begin
				run    = 1'b1;
				clr    = 1'b1;
				skip_d = 1'b1;
			end else if ((u >= CH_A && u <= CH_G) || u == CH_O || u == CH_N || u == CH_L ||
			             u == CH_P || u == CH_T || u == CH_M || u == CH_LT ||
			             u == CH_GT || u == CH_TILDE) begin
				run      = 1'b1;
				clr      = 1'b1;
				new_pend = 1'b1;
			end else begin
				clr    = 1'b1;
				skip_d = 1'b1;
			end
		end

		if (clr) begin
			pend_d   = CH_NUL;
			sub_d    = CH_NUL;
			num_d    = '0;
			in_run_d = 1'b0;
			acc_d    = '0;
			dots_d   = '0;
			legato_d = 1'b0;
		end
		if (new_pend) pend_d = u;
	end

	// run the pending command against the player state
	always_comb begin
		oct_d    = oct_q;
		prev_d   = prev_q;
		track_d  = track_q;
		deflen_d = deflen_q;
		tempo_d  = tempo_q;
		art_d    = art_q;
		is_play  = 1'b0;
		is_pause = 1'b0;
		art_eff  = legato_q ? mstseq_pkg::ART_LEGATO : art_q;
		len_sel  = (num_q != '0) ? num_q : deflen_q;
		p_len    = len_sel;
		idx      = letter_index(pend_q[2:0] - 3'd1);
		diff     = $signed({2'b00, idx}) - $signed({prev_q[4], prev_q});
		oct_adj  = oct_q;
		if (track_q && !prev_q[4]) begin
			if (diff < -6'sd6 && oct_q < 5'sd6) oct_adj = oct_q + 5'sd1;
			else if (diff > 6'sd6 && oct_q > 5'sd0) oct_adj = oct_q - 5'sd1;
		end
		oct_ext  = {{10{oct_adj[4]}}, oct_adj};
		note_val = (oct_ext <<< 3) + (oct_ext <<< 2) + $signed({11'd0, idx})
		           + {{13{acc_q[1]}}, acc_q} + 15'sd1;

		if (pend_q >= CH_A && pend_q <= CH_G) begin
			is_play = run;
			if (run) begin
				oct_d  = oct_adj;
				prev_d = $signed({1'b0, idx});
			end
		end else if (pend_q == CH_O) begin
			if (run) begin
				if (sub_q != CH_NUL) begin
					track_d = (sub_q == CH_L);
				end else begin
					oct_d  = (num_q > 14'd6) ? 5'sd6 : $signed({2'b00, num_q[2:0]});
					prev_d = -5'sd1;
				end
			end
		end else if (pend_q == CH_GT) begin
			if (run) begin
				if (oct_q != 5'sd15) oct_d = oct_q + 5'sd1;
				prev_d = -5'sd1;
			end
		end else if (pend_q == CH_LT) begin
			if (run) begin
				if (oct_q != -5'sd8) oct_d = oct_q - 5'sd1;
				prev_d = -5'sd1;
			end
		end else if (pend_q == CH_N) begin
			is_play  = run;
			note_val = $signed({1'b0, num_q});
			p_len    = deflen_q;
		end else if (pend_q == CH_L) begin
			if (run && num_q != '0) deflen_d = num_q;
		end else if (pend_q == CH_P || pend_q == CH_TILDE) begin
			is_play  = run;
			is_pause = 1'b1;
		end else if (pend_q == CH_T) begin
			if (run) begin
				if (num_q < 14'd10) tempo_d = 9'd10;
				else if (num_q > 14'd300) tempo_d = 9'd300;
				else tempo_d = num_q[8:0];
			end
		end else if (pend_q == CH_M) begin
			if (run) begin
				if (sub_q == CH_L) art_d = mstseq_pkg::ART_LEGATO;
				else if (sub_q == CH_S) art_d = mstseq_pkg::ART_STACCATO;
				else art_d = mstseq_pkg::ART_NORMAL;
			end
		end

		p_rest  = is_pause || note_val == 15'sd0;
		p_in    = note_val >= 15'sd1 && note_val <= NOTE_HI;
		p_two   = !p_rest && art_eff != mstseq_pkg::ART_LEGATO;
		den_new = 23'(tempo_q) * 23'(p_len);
		if (den_new == '0) den_new = 23'd1;
	end

	assign status.play_req = is_play && (p_rest || p_in);
	assign status.two      = two_q;
	assign status.div_last = (cnt_q == 5'(mstseq_pkg::DIV_STEPS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q   <= '0;
			sub_q    <= '0;
			num_q    <= '0;
			in_run_q <= 1'b0;
			acc_q    <= '0;
			dots_q   <= '0;
			legato_q <= 1'b0;
			skip_q   <= 1'b0;
			oct_q    <= 5'sd4;
			prev_q   <= -5'sd1;
			track_q  <= 1'b0;
			deflen_q <= 14'd4;
			tempo_q  <= 9'd120;
			art_q    <= mstseq_pkg::ART_NORMAL;
			two_q    <= 1'b0;
		end else if (cmd.load) begin
			pend_q   <= pend_d;
			sub_q    <= sub_d;
			num_q    <= num_d;
			in_run_q <= in_run_d;
			acc_q    <= acc_d;
			dots_q   <= dots_d;
			legato_q <= legato_d;
			skip_q   <= skip_d;
			oct_q    <= oct_d;
			prev_q   <= prev_d;
			track_q  <= track_d;
			deflen_q <= deflen_d;
			tempo_q  <= tempo_d;
			art_q    <= art_d;
			two_q    <= p_two;
		end
	end

	// restoring divider: quotient bits shift into the dividend register
	logic [23:0] r_sh;
	logic        ge;
	assign r_sh = {rem_q, quo_q[17]};
	assign ge   = r_sh >= {1'b0, den_q};

	logic [14:0] tot;
	logic [15:0] tot_d, on_t;
	logic [17:0] t3;
	logic [18:0] t7;
	assign tot   = quo_q[14:0];
	assign tot_d = {1'b0, tot} + {1'b0, tot} - {1'b0, tot >> evdots_q};
	assign t3    = {1'b0, tot_d, 1'b0} + {2'b0, tot_d};
	assign t7    = {tot_d, 3'b0} - {3'b0, tot_d};
	assign on_t  = stac_q ? t3[17:2] : t7[18:3];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			note_q   <= p_rest ? 7'd0 : note_val[6:0];
			stac_q   <= art_eff == mstseq_pkg::ART_STACCATO;
			evdots_q <= dots_q;
			den_q    <= den_new;
			rem_q    <= '0;
			quo_q    <= mstseq_pkg::WHOLE_MS;
			cnt_q    <= '0;
		end else if (cmd.div_step) begin
			rem_q <= ge ? 23'(r_sh - {1'b0, den_q}) : r_sh[22:0];
			quo_q <= {quo_q[16:0], ge};
			cnt_q <= cnt_q + 5'd1;
		end
		if (cmd.scale) begin
			dur_a_q <= two_q ? on_t : tot_d;
			dur_b_q <= tot_d - on_t;
		end
	end

	always_comb begin
		if (cmd.sel_second) begin
			out_word.note_number = '0;
			out_word.duration_ms = dur_b_q;
			out_word.last_of_run = 1'b1;
		end else begin
			out_word.note_number = note_q;
			out_word.duration_ms = dur_a_q;
			out_word.last_of_run = !two_q;
		end
	end

endmodule
`default_nettype wire

>>> rtl/core/music_string_tone_sequencer.sv
// Channel | Direction | Handshake             | Word
// in      | input     | in_valid / in_ready   | in_word  (char_code, line_end)
// out     | output    | out_valid / out_ready | out_word (note_number, duration_ms, last_of_run)
//
// A character that causes no tone event is taken back to back.
// A character that plays is decoded, passes through the duration divider (one
// quotient bit per cycle) and is scaled, then leaves as 1 or 2 words, each
// held until out_ready.
// Reset (arst_n low) restores octave 4, length 4, tempo 120, normal articulation.
// Input is held off while an event is divided or scaled or its words wait on out_ready.
`default_nettype none
module music_string_tone_sequencer #(
	parameter int unsigned HIGHEST_NOTE = mstseq_pkg::HIGHEST_NOTE_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire mstseq_pkg::in_word_t in_word,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output mstseq_pkg::out_word_t     out_word
);

	// Controller sequences decode, divide, scale and the emit words.
	mstseq_pkg::dp_cmd_t    cmd;
	mstseq_pkg::dp_status_t status;

	mstseq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.out_ready (out_ready),
		.status    (status),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	// Datapath holds the parser and player state, the divider and the output words.
	mstseq_dp #(
		.HIGHEST_NOTE (HIGHEST_NOTE)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_word  (in_word),
		.cmd      (cmd),
		.status   (status),
		.out_word (out_word)
	);

endmodule
`default_nettype wire

>>> rtl/core/mstseq_checker.sv
`default_nettype none
module mstseq_checker (
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  in_valid,
	input wire logic                  in_ready,
	input wire mstseq_pkg::in_word_t  in_word,
	input wire logic                  out_valid,
	input wire logic                  out_ready,
	input wire mstseq_pkg::out_word_t out_word
);

	// hold a stalled word
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_word))
		else $error("output word changed while stalled");

	// one character at a time: no input taken while a word is shown
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input ready while output pending");

	// a tone that is not last is followed by its closing rest
	a_rest_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && !out_word.last_of_run |=>
		out_valid && out_word.note_number == 7'd0 && out_word.last_of_run)
		else $error("missing closing rest");

	// a split event starts with a real tone
	a_split_tone: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_word.last_of_run |-> out_word.note_number != 7'd0)
		else $error("split event without tone");

endmodule

bind music_string_tone_sequencer mstseq_checker u_mstseq_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_word   (in_word),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_word  (out_word)
);
`default_nettype wire
